### rtl/frasm_pkg.sv
// Shared types, codes and default sizes for the fragment reassembler.
package frasm_pkg;

    localparam int SLOTS_DEF             = 4;
    localparam int MAX_MESSAGE_BYTES_DEF = 2048;
    localparam int MAX_FRAGMENT_BYTES    = 246;

    localparam logic [1:0] CMD_FRAG    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        ST_ACCEPTED     = 3'd0,
        ST_COMPLETE     = 3'd1,
        ST_TOO_SMALL    = 3'd2,
        ST_BAD_FIRST    = 3'd3,
        ST_OUT_OF_ORDER = 3'd4,
        ST_NO_SLOT      = 3'd5,
        ST_OVERFLOW     = 3'd6,
        ST_READ         = 3'd7
    } status_t;

endpackage

### rtl/frasm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module frasm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/fragment_reassembler.sv
// Fragment reassembler: slot table in flops, payload bytes in one RAM.
// Throughput: one fragment word or release per cycle while req_stall is low; a read word
//   holds the request side during the registered read of the payload RAM.
// Results: a fragment result is registered as its word is taken; read data passes the
//   registered read port of the payload RAM and then the output register.
// Reset (rst_n, async, active low) clears the slot table, frame state, the pending read
//   and the output valid bit; output data and payload RAM contents are undefined until written.
module fragment_reassembler
    import frasm_pkg::*;
#(
    parameter int SLOTS             = SLOTS_DEF,
    parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  msg_id,
    input  logic [7:0]  frag_index,
    input  logic [7:0]  frag_count,
    input  logic [7:0]  frag_size,
    input  logic        byte_valid,
    input  logic [7:0]  data_byte,
    input  logic        frame_last,
    input  logic [1:0]  sel_slot,
    input  logic [10:0] read_offset,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [7:0]  out_id,
    output logic [1:0]  out_slot,
    output logic [11:0] msg_size,
    output logic [7:0]  read_byte
);

    // slot index, message length and payload address widths
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW    = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int SUMW  = ((LW > 8) ? LW : 8) + 1;
    localparam int DEPTH = SLOTS * MAX_MESSAGE_BYTES;
    localparam int AW    = $clog2(DEPTH);

    // slot table
    logic          slot_busy_reg       [SLOTS];
    logic          slot_done_reg       [SLOTS];
    logic [7:0]    slot_msg_id_reg     [SLOTS];
    logic [7:0]    slot_last_index_reg [SLOTS];
    logic [7:0]    slot_frag_total_reg [SLOTS];
    logic [LW-1:0] slot_length_reg     [SLOTS];
    logic          slot_busy_next       [SLOTS];
    logic          slot_done_next       [SLOTS];
    logic [7:0]    slot_msg_id_next     [SLOTS];
    logic [7:0]    slot_last_index_next [SLOTS];
    logic [7:0]    slot_frag_total_next [SLOTS];
    logic [LW-1:0] slot_length_next     [SLOTS];

    // frame in progress
    logic          in_frame_reg, in_frame_next;
    status_t       frame_verdict_reg, frame_verdict_next;
    logic [SW-1:0] frame_slot_reg, frame_slot_next;
    logic [LW-1:0] write_pointer_reg, write_pointer_next;

    // read waiting on the RAM
    logic          rd_pend_reg;
    logic [7:0]    rd_id_reg;
    logic [1:0]    rd_slot_reg;
    logic [LW-1:0] rd_len_reg;
    logic          rd_zero_reg;

    // output register
    logic          rsp_valid_reg;
    status_t       status_reg;
    logic [7:0]    out_id_reg;
    logic [1:0]    out_slot_reg;
    logic [11:0]   msg_size_reg;
    logic [7:0]    read_byte_reg;

    logic          req_acc;
    logic          rsp_take;

    // slot match and free search
    logic          hit_any, free_any;
    logic [SW-1:0] hit_idx, free_idx;

    // read addressing
    logic [8:0]    sel_ext;
    logic [SW-1:0] sel_idx;
    logic          sel_ok, off_ok;

    // payload RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    // result of the word being taken
    logic          res_valid;
    status_t       res_status;
    logic [7:0]    res_id;
    logic [SW-1:0] res_slot;
    logic [LW-1:0] res_len;
    logic [8:0]    res_slot_ext;
    logic [16:0]   res_len_ext;
    logic [16:0]   rd_len_ext;

    // working values of the fragment path
    status_t       v;
    logic [SW-1:0] fs, hdr_slot;
    logic [LW-1:0] wp, len_cur;
    logic [SUMW-1:0] sum;
    logic          hdr_ok;

    // A pending read owns the output register next cycle, so hold the
    // request side; otherwise take a word whenever the output can move.
    assign req_stall = rd_pend_reg || (rsp_valid_reg && rsp_stall);
    assign req_acc   = req_valid && !req_stall;
    assign rsp_take  = rsp_valid_reg && !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign out_id    = out_id_reg;
    assign out_slot  = out_slot_reg;
    assign msg_size  = msg_size_reg;
    assign read_byte = read_byte_reg;

    assign sel_ext = {7'd0, sel_slot};
    assign sel_idx = sel_ext[SW-1:0];
    assign sel_ok  = sel_ext < 9'(SLOTS);
    assign off_ok  = 17'(read_offset) < 17'(MAX_MESSAGE_BYTES);

    // Open receiving slot with this id, and lowest free slot.
    // Descending scan so the lowest index wins.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (slot_busy_reg[s] && !slot_done_reg[s] && slot_msg_id_reg[s] == msg_id)
            begin
                hit_any = 1'b1;
                hit_idx = SW'(s);
            end
            if (!slot_busy_reg[s])
            begin
                free_any = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    // Main read-modify-write of the slot table and frame state.
    always_comb
    begin
        slot_busy_next       = slot_busy_reg;
        slot_done_next       = slot_done_reg;
        slot_msg_id_next     = slot_msg_id_reg;
        slot_last_index_next = slot_last_index_reg;
        slot_frag_total_next = slot_frag_total_reg;
        slot_length_next     = slot_length_reg;
        in_frame_next        = in_frame_reg;

        v        = frame_verdict_reg;
        fs       = frame_slot_reg;
        wp       = write_pointer_reg;
        hdr_slot = '0;
        hdr_ok   = 1'b0;
        len_cur  = '0;
        sum      = '0;

        res_valid  = 1'b0;
        res_status = ST_ACCEPTED;
        res_id     = '0;
        res_slot   = '0;
        res_len    = '0;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = data_byte;
        ram_re    = 1'b0;
        ram_raddr = AW'(sel_idx) * AW'(MAX_MESSAGE_BYTES) + AW'(read_offset);

        if (req_acc)
        begin
            case (cmd)
                CMD_READ:
                begin
                    ram_re = 1'b1;
                end
                CMD_RELEASE:
                begin
                    if (sel_ok && slot_busy_reg[sel_idx] && slot_done_reg[sel_idx])
                    begin
                        slot_busy_next[sel_idx] = 1'b0;
                        slot_done_next[sel_idx] = 1'b0;
                    end
                end
                CMD_FRAG:
                begin
                    // header checks on the first word of a frame
                    if (!in_frame_reg)
                    begin
                        in_frame_next = 1'b1;
                        v = ST_ACCEPTED;
                        if (!byte_valid)
                        begin
                            v          = ST_TOO_SMALL;
                            res_valid  = 1'b1;
                            res_status = ST_TOO_SMALL;
                            res_id     = msg_id;
                        end
                        else
                        begin
                            if (!hit_any)
                            begin
                                if (frag_index != 8'd0 || frag_count == 8'd0)
                                begin
                                    v          = ST_BAD_FIRST;
                                    res_valid  = 1'b1;
                                    res_status = ST_BAD_FIRST;
                                    res_id     = msg_id;
                                end
                                else if (!free_any)
                                begin
                                    v          = ST_NO_SLOT;
                                    res_valid  = 1'b1;
                                    res_status = ST_NO_SLOT;
                                    res_id     = msg_id;
                                end
                                else
                                begin
                                    // open the slot; entry fields stay even if
                                    // the size check below frees it again
                                    hdr_slot = free_idx;
                                    hdr_ok   = 1'b1;
                                    slot_busy_next[free_idx]       = 1'b1;
                                    slot_done_next[free_idx]       = 1'b0;
                                    slot_msg_id_next[free_idx]     = msg_id;
                                    slot_last_index_next[free_idx] = 8'd0;
                                    slot_frag_total_next[free_idx] = frag_count;
                                    slot_length_next[free_idx]     = '0;
                                end
                            end
                            else if ({1'b0, frag_index} !=
                                     {1'b0, slot_last_index_reg[hit_idx]} + 9'd1 ||
                                     frag_count != slot_frag_total_reg[hit_idx])
                            begin
                                v          = ST_OUT_OF_ORDER;
                                slot_busy_next[hit_idx] = 1'b0;
                                slot_done_next[hit_idx] = 1'b0;
                                res_valid  = 1'b1;
                                res_status = ST_OUT_OF_ORDER;
                                res_id     = msg_id;
                                res_slot   = hit_idx;
                                res_len    = slot_length_reg[hit_idx];
                            end
                            else
                            begin
                                hdr_slot = hit_idx;
                                hdr_ok   = 1'b1;
                            end

                            if (hdr_ok)
                            begin
                                len_cur = slot_length_next[hdr_slot];
                                sum     = SUMW'(len_cur) + SUMW'(frag_size);
                                if (frag_size > 8'(MAX_FRAGMENT_BYTES) ||
                                    sum > SUMW'(MAX_MESSAGE_BYTES))
                                begin
                                    v          = ST_OVERFLOW;
                                    slot_busy_next[hdr_slot] = 1'b0;
                                    slot_done_next[hdr_slot] = 1'b0;
                                    res_valid  = 1'b1;
                                    res_status = ST_OVERFLOW;
                                    res_id     = msg_id;
                                    res_slot   = hdr_slot;
                                    res_len    = len_cur;
                                end
                                else
                                begin
                                    fs = hdr_slot;
                                    wp = len_cur;
                                    slot_last_index_next[hdr_slot] = frag_index;
                                    slot_length_next[hdr_slot]     = LW'(sum);
                                end
                            end
                        end
                    end

                    // payload byte
                    if (v == ST_ACCEPTED && byte_valid)
                    begin
                        if (wp >= LW'(MAX_MESSAGE_BYTES))
                        begin
                            v          = ST_OVERFLOW;
                            slot_busy_next[fs] = 1'b0;
                            slot_done_next[fs] = 1'b0;
                            res_valid  = 1'b1;
                            res_status = ST_OVERFLOW;
                            res_id     = slot_msg_id_next[fs];
                            res_slot   = fs;
                            res_len    = wp;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(fs) * AW'(MAX_MESSAGE_BYTES) + AW'(wp);
                            wp        = wp + LW'(1);
                        end
                    end

                    // end of frame: report, and mark done on the last index
                    if (frame_last)
                    begin
                        in_frame_next = 1'b0;
                        if (v == ST_ACCEPTED)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_ACCEPTED;
                            if ({1'b0, slot_last_index_next[fs]} + 9'd1 ==
                                {1'b0, slot_frag_total_next[fs]})
                            begin
                                slot_done_next[fs] = 1'b1;
                                res_status = ST_COMPLETE;
                            end
                            res_id   = slot_msg_id_next[fs];
                            res_slot = fs;
                            res_len  = slot_length_next[fs];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        frame_verdict_next = v;
        frame_slot_next    = fs;
        write_pointer_next = wp;
    end

    assign res_slot_ext = 9'(res_slot);
    assign res_len_ext  = 17'(res_len);
    assign rd_len_ext   = 17'(rd_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_busy_reg[s]       <= 1'b0;
                slot_done_reg[s]       <= 1'b0;
                slot_msg_id_reg[s]     <= '0;
                slot_last_index_reg[s] <= '0;
                slot_frag_total_reg[s] <= '0;
                slot_length_reg[s]     <= '0;
            end
            in_frame_reg      <= 1'b0;
            frame_verdict_reg <= ST_ACCEPTED;
            frame_slot_reg    <= '0;
            write_pointer_reg <= '0;
            rd_pend_reg       <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            slot_busy_reg       <= slot_busy_next;
            slot_done_reg       <= slot_done_next;
            slot_msg_id_reg     <= slot_msg_id_next;
            slot_last_index_reg <= slot_last_index_next;
            slot_frag_total_reg <= slot_frag_total_next;
            slot_length_reg     <= slot_length_next;
            in_frame_reg        <= in_frame_next;
            frame_verdict_reg   <= frame_verdict_next;
            frame_slot_reg      <= frame_slot_next;
            write_pointer_reg   <= write_pointer_next;

            rd_pend_reg <= req_acc && cmd == CMD_READ;

            // a pending read always finds the output register empty
            if (rd_pend_reg || (req_acc && res_valid))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_take)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the read in flight and of the output register
    always_ff @(posedge clk)
    begin
        if (req_acc && cmd == CMD_READ)
        begin
            rd_id_reg   <= sel_ok ? slot_msg_id_reg[sel_idx] : 8'd0;
            rd_len_reg  <= sel_ok ? slot_length_reg[sel_idx] : '0;
            rd_slot_reg <= sel_slot;
            rd_zero_reg <= !(sel_ok && off_ok);
        end

        if (rd_pend_reg)
        begin
            status_reg    <= ST_READ;
            out_id_reg    <= rd_id_reg;
            out_slot_reg  <= rd_slot_reg;
            msg_size_reg  <= rd_len_ext[11:0];
            read_byte_reg <= rd_zero_reg ? 8'd0 : ram_rdata;
        end
        else if (req_acc && res_valid)
        begin
            status_reg    <= res_status;
            out_id_reg    <= res_id;
            out_slot_reg  <= res_slot_ext[1:0];
            msg_size_reg  <= res_len_ext[11:0];
            read_byte_reg <= 8'd0;
        end
    end

    frasm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### rtl/frasm_checker.sv
// Port-level assertions for the fragment reassembler, bound to the top level.
module frasm_checker
    import frasm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic [1:0]  cmd,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [2:0]  status,
    input logic [7:0]  out_id,
    input logic [1:0]  out_slot,
    input logic [11:0] msg_size,
    input logic [7:0]  read_byte
);

    // a stalled response holds its word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(out_id) &&
            $stable(out_slot) && $stable(msg_size) && $stable(read_byte))
        else $error("response word changed while stalled");

    // a read blocks the request side while the RAM answers
    a_read_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && cmd == CMD_READ |=> req_stall)
        else $error("request taken during pending read");

    // only read words carry a data byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_READ |-> read_byte == 8'd0)
        else $error("data byte on a non-read response");

    // header rejections name no slot and no size
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_TOO_SMALL || status == ST_BAD_FIRST ||
            status == ST_NO_SLOT) |-> out_slot == 2'd0 && msg_size == 12'd0)
        else $error("rejection carries slot or size");

endmodule

bind fragment_reassembler frasm_checker u_frasm_checker (.*);
